### rtl/double_ended_queue_unit_macros.svh
// assertion macros used by the queue rtl
`ifndef DOUBLE_ENDED_QUEUE_UNIT_MACROS_SVH
`define DOUBLE_ENDED_QUEUE_UNIT_MACROS_SVH

// same-cycle implication
`define DEQ_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("queue assertion failed");

// next-cycle implication
`define DEQ_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("queue assertion failed");

`endif

### rtl/deq_pkg.sv
// constants, codes and ring helper for the double-ended queue
package deq_pkg;

   localparam int DEPTH  = 32;
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W  = $clog2(DEPTH + 1);
   localparam int WORD_W = 32;

   localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

   localparam logic [1:0] KIND_PUSH     = 2'd0;
   localparam logic [1:0] KIND_POP_HEAD = 2'd1;
   localparam logic [1:0] KIND_POP_TAIL = 2'd2;
   localparam logic [1:0] KIND_READ_ALL = 2'd3;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_EMPTY = 2'd1;
   localparam logic [1:0] ST_FULL  = 2'd2;

   // ring slot of base plus offset, offset at most DEPTH
   function automatic logic [ADDR_W-1:0] wrap_add(input logic [ADDR_W-1:0] base,
                                                  input logic [CNT_W-1:0] off);
      logic [CNT_W:0] sum;
      sum = (CNT_W+1)'(base) + (CNT_W+1)'(off);
      if (sum >= (CNT_W+1)'(DEPTH)) begin
         sum = sum - (CNT_W+1)'(DEPTH);
      end
      return ADDR_W'(sum);
   endfunction

endpackage

### rtl/deq_ram.sv
// generic single-write, single-read ram with registered read data
module deq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32
) (
   input  logic                                      clock,
   input  logic                                      wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                          wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                          rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/double_ended_queue_unit.sv
// double-ended queue of signed words held in a ring buffer ram
// push, and any request on an empty queue, has its result registered in the cycle after acceptance
// pops pass their word through the ram read data register and then the response registers
// read-out streams one held word per cycle after the first ram read, stalled by rsp_ready
// the next request is taken once the last result of the current one is registered and the output is free
// synchronous reset empties the queue and zeroes the head slot; ram contents are not cleared
`include "double_ended_queue_unit_macros.svh"

module double_ended_queue_unit (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [1:0]                 req_kind,
   input  logic signed [31:0]         req_value,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [1:0]                 rsp_status,
   output logic signed [31:0]         rsp_word,
   output logic                       rsp_final_res
);

   typedef enum logic [1:0] {
      S_IDLE = 2'b01,
      S_SEND = 2'b10
   } state_type;

   state_type                      state_ff, state_in;
   logic [deq_pkg::ADDR_W-1:0]     head_ff, head_in;
   logic [deq_pkg::CNT_W-1:0]      occ_ff, occ_in;
   logic [deq_pkg::ADDR_W-1:0]     rd_addr_ff, rd_addr_in;
   logic [deq_pkg::CNT_W-1:0]      remain_ff, remain_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   logic [1:0]                     rsp_status_ff, rsp_status_in;
   logic [deq_pkg::WORD_W-1:0]     rsp_word_ff, rsp_word_in;
   logic                           rsp_final_ff, rsp_final_in;

   logic                           out_free;
   logic                           accept;
   logic                           wr_en;
   logic [deq_pkg::ADDR_W-1:0]     wr_addr;
   logic [deq_pkg::WORD_W-1:0]     rd_data;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == S_IDLE) && out_free;
   assign accept    = req_valid && req_ready;
   assign wr_addr   = deq_pkg::wrap_add(head_ff, occ_ff);

   always_comb begin
      state_in      = state_ff;
      head_in       = head_ff;
      occ_in        = occ_ff;
      rd_addr_in    = rd_addr_ff;
      remain_in     = remain_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_status_in = rsp_status_ff;
      rsp_word_in   = rsp_word_ff;
      rsp_final_in  = rsp_final_ff;
      wr_en         = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               unique case (req_kind)
                  deq_pkg::KIND_PUSH: begin
                     rsp_valid_in = 1'b1;
                     rsp_word_in  = req_value;
                     rsp_final_in = 1'b1;
                     if (occ_ff == deq_pkg::CNT_FULL) begin
                        rsp_status_in = deq_pkg::ST_FULL;
                     end else begin
                        rsp_status_in = deq_pkg::ST_OK;
                        wr_en         = 1'b1;
                        occ_in        = occ_ff + deq_pkg::CNT_ONE;
                     end
                  end
                  default: begin
                     if (occ_ff == '0) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = deq_pkg::ST_EMPTY;
                        rsp_word_in   = '0;
                        rsp_final_in  = 1'b1;
                     end else begin
                        state_in  = S_SEND;
                        remain_in = '0;
                        priority if (req_kind == deq_pkg::KIND_POP_HEAD) begin
                           rd_addr_in = head_ff;
                           head_in    = deq_pkg::wrap_add(head_ff, deq_pkg::CNT_ONE);
                           occ_in     = occ_ff - deq_pkg::CNT_ONE;
                        end else if (req_kind == deq_pkg::KIND_POP_TAIL) begin
                           rd_addr_in = deq_pkg::wrap_add(head_ff,
                                                          occ_ff - deq_pkg::CNT_ONE);
                           occ_in     = occ_ff - deq_pkg::CNT_ONE;
                        end else begin
                           rd_addr_in = head_ff;
                           remain_in  = occ_ff - deq_pkg::CNT_ONE;
                        end
                     end
                  end
               endcase
            end
         end
         S_SEND: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = deq_pkg::ST_OK;
               rsp_word_in   = rd_data;
               rsp_final_in  = (remain_ff == '0);
               if (remain_ff != '0) begin
                  remain_in  = remain_ff - deq_pkg::CNT_ONE;
                  rd_addr_in = deq_pkg::wrap_add(rd_addr_ff, deq_pkg::CNT_ONE);
               end else begin
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         head_ff      <= '0;
         occ_ff       <= '0;
         remain_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         occ_ff       <= occ_in;
         remain_ff    <= remain_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rd_addr_ff    <= rd_addr_in;
      rsp_status_ff <= rsp_status_in;
      rsp_word_ff   <= rsp_word_in;
      rsp_final_ff  <= rsp_final_in;
   end

   deq_ram #(
      .WIDTH (deq_pkg::WORD_W),
      .DEPTH (deq_pkg::DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (req_value),
      .rd_addr (rd_addr_in),
      .rd_data (rd_data)
   );

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_word      = rsp_word_ff;
   assign rsp_final_res = rsp_final_ff;

   `DEQ_ASSERT_NOW(a_occ_bound, clock, reset, 1'b1, occ_ff <= deq_pkg::CNT_FULL)
   `DEQ_ASSERT_NEXT(a_send_holds_occ, clock, reset, state_ff == S_SEND, occ_ff == $past(occ_ff))
   `DEQ_ASSERT_NEXT(a_push_grows, clock, reset, accept && req_kind == deq_pkg::KIND_PUSH && occ_ff != deq_pkg::CNT_FULL, occ_ff == $past(occ_ff) + deq_pkg::CNT_ONE)
   `DEQ_ASSERT_NEXT(a_read_enters_send, clock, reset, accept && req_kind != deq_pkg::KIND_PUSH && occ_ff != '0, state_ff == S_SEND)

endmodule
